/* hdl/lrusd_pkg.sv */
// Shared types and codes for the LRU stack distance histogram block.
// No dependencies; imported by lrusd_cell and lru_stack_distance_histogram.

package lrusd_pkg;

    // Token that walks the stack chain, one cell per cycle
    typedef struct packed {
        logic active;
        logic done;
        logic hit;
    } tok_t;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] KIND_WITHIN  = 2'd0;
    localparam logic [1:0] KIND_BEYOND  = 2'd1;
    localparam logic [1:0] KIND_COLD    = 2'd2;
    localparam logic [1:0] KIND_READOUT = 2'd3;

endpackage

/* hdl/lru_stack_distance_histogram.sv */
// Top level of the LRU stack distance histogram: command decode, stack chain,
// seen-key map, histogram memory and output register.
// Depends on lrusd_pkg and lrusd_cell.
//
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------
//  input    | in_valid / in_ready | command, key, bucket
//  output   | out_valid/out_ready | kind, distance, count
//  config   | cfg_we              | cfg_wdata (size limit)
//
// An access sends its token down the whole cell chain, one cell per cycle, then
// reads the histogram and writes the incremented bucket in the update step.
// A bucket read does one histogram memory read.
// After reset a clearing pass zeroes the seen map and the histogram; no word is
// accepted meanwhile. A full output register stalls the update and readout
// steps; the next word is taken once the result is in the output register.

module lru_stack_distance_histogram #(
    parameter int STACK_DEPTH = 256,
    parameter int KEY_BITS    = 16,
    parameter int COUNT_BITS  = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [8:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [15:0]           key,
    input  logic [8:0]            bucket,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [7:0]            distance,
    output logic [COUNT_BITS-1:0] count
);
    import lrusd_pkg::*;

    localparam int HIST_N = STACK_DEPTH + 3;
    localparam int CNT_W  = $clog2(HIST_N);
    localparam int MAP_N  = 1 << KEY_BITS;
    localparam int CLR_N  = (MAP_N > HIST_N) ? MAP_N : HIST_N;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int SW     = (CNT_W > 9) ? CNT_W : 9;

    localparam logic [CLR_W:0]   MAP_LIM   = (CLR_W+1)'(MAP_N);
    localparam logic [CLR_W:0]   HIST_LIM  = (CLR_W+1)'(HIST_N);
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_N - 1);
    localparam logic [SW-1:0]    DEPTH_SW  = SW'(STACK_DEPTH);
    localparam logic [SW-1:0]    HIST_SW   = SW'(HIST_N);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_WAVE    = 3'd2;
    localparam logic [2:0] ST_UPDATE  = 3'd3;
    localparam logic [2:0] ST_READOUT = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CLR_W-1:0]      clr_reg, clr_next;
    logic [8:0]            size_limit_reg, size_limit_next;
    logic [KEY_BITS-1:0]   probe_reg, probe_next;
    logic                  head_reg, head_next;
    logic                  oob_reg, oob_next;
    logic [1:0]            res_kind_reg, res_kind_next;
    logic [7:0]            res_dist_reg, res_dist_next;
    logic [CNT_W-1:0]      res_idx_reg, res_idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            kind_reg, kind_next;
    logic [7:0]            distance_reg, distance_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  seen_mem [MAP_N];
    logic [COUNT_BITS-1:0] hist_mem [HIST_N];
    logic                  seen_q_reg;
    logic [COUNT_BITS-1:0] hist_q_reg;

    logic                  seen_we, seen_wd, seen_re;
    logic [KEY_BITS-1:0]   seen_wa, seen_ra;
    logic                  hist_we, hist_re;
    logic [CNT_W-1:0]      hist_wa, hist_ra;
    logic [COUNT_BITS-1:0] hist_wd;

    tok_t                  tok_w [STACK_DEPTH+1];
    logic [KEY_BITS-1:0]   key_w [STACK_DEPTH+1];
    logic [CNT_W-1:0]      pos_w [STACK_DEPTH+1];

    logic                  accept, slot_free, tail_seen;
    logic [KEY_BITS-1:0]   key_in;
    logic [SW-1:0]         cs_ext, bkt_ext;
    logic [CNT_W-1:0]      size_eff, tail_pos;
    logic [1:0]            calc_kind;
    logic [7:0]            calc_dist;
    logic [CNT_W-1:0]      calc_idx;

    // stack chain
    assign tok_w[0] = '{active: head_reg, done: 1'b0, hit: 1'b0};
    assign key_w[0] = probe_reg;
    assign pos_w[0] = '0;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        lrusd_cell #(
            .KEY_BITS (KEY_BITS),
            .POS_W    (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .probe   (probe_reg),
            .tok_in  (tok_w[i]),
            .key_in  (key_w[i]),
            .pos_in  (pos_w[i]),
            .tok_out (tok_w[i+1]),
            .key_out (key_w[i+1]),
            .pos_out (pos_w[i+1])
        );
    end

    assign tail_seen = tok_w[STACK_DEPTH].active || tok_w[STACK_DEPTH].done;
    assign tail_pos  = pos_w[STACK_DEPTH];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign key_in    = KEY_BITS'(key);
    assign bkt_ext   = SW'(bucket);

    // effective cache size, clamped to 1..STACK_DEPTH
    assign cs_ext   = SW'(size_limit_reg);
    assign size_eff = (cs_ext == '0) ? CNT_W'(1) :
                      (cs_ext > DEPTH_SW) ? DEPTH_CNT : CNT_W'(cs_ext);

    always_comb
    begin
        calc_dist = '0;
        if (!seen_q_reg)
        begin
            calc_kind = KIND_COLD;
            calc_idx  = size_eff + CNT_W'(2);
        end
        else if (!tok_w[STACK_DEPTH].hit || (tail_pos >= size_eff))
        begin
            calc_kind = KIND_BEYOND;
            calc_idx  = size_eff + CNT_W'(1);
        end
        else
        begin
            calc_kind = KIND_WITHIN;
            calc_idx  = tail_pos + CNT_W'(1);
            calc_dist = 8'(tail_pos);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        size_limit_next = cfg_we ? cfg_wdata : size_limit_reg;
        probe_next      = probe_reg;
        head_next       = 1'b0;
        oob_next        = oob_reg;
        res_kind_next   = res_kind_reg;
        res_dist_next   = res_dist_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        distance_next   = distance_reg;
        count_next      = count_reg;
        seen_we         = 1'b0;
        seen_wa         = probe_reg;
        seen_wd         = 1'b1;
        seen_re         = 1'b0;
        seen_ra         = key_in;
        hist_we         = 1'b0;
        hist_wa         = res_idx_reg;
        hist_wd         = hist_q_reg + 1'b1;
        hist_re         = 1'b0;
        hist_ra         = calc_idx;

        case (state_reg)
            ST_CLEAR:
            begin
                seen_we  = ({1'b0, clr_reg} < MAP_LIM);
                seen_wa  = clr_reg[KEY_BITS-1:0];
                seen_wd  = 1'b0;
                hist_we  = ({1'b0, clr_reg} < HIST_LIM);
                hist_wa  = clr_reg[CNT_W-1:0];
                hist_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_READ)
                    begin
                        hist_re    = 1'b1;
                        hist_ra    = CNT_W'(bkt_ext);
                        oob_next   = !(bkt_ext < HIST_SW);
                        state_next = ST_READOUT;
                    end
                    else
                    begin
                        seen_re    = 1'b1;
                        probe_next = key_in;
                        head_next  = 1'b1;
                        state_next = ST_WAVE;
                    end
                end
            end
            ST_WAVE:
            begin
                if (tail_seen)
                begin
                    hist_re       = 1'b1;
                    res_kind_next = calc_kind;
                    res_dist_next = calc_dist;
                    res_idx_next  = calc_idx;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    hist_we        = 1'b1;
                    seen_we        = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = res_kind_reg;
                    distance_next  = res_dist_reg;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_READOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_READOUT;
                    distance_next  = '0;
                    count_next     = oob_reg ? '0 : hist_q_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            size_limit_reg <= 9'd256;
            head_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            size_limit_reg <= size_limit_next;
            head_reg       <= head_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg    <= probe_next;
        oob_reg      <= oob_next;
        res_kind_reg <= res_kind_next;
        res_dist_reg <= res_dist_next;
        res_idx_reg  <= res_idx_next;
        kind_reg     <= kind_next;
        distance_reg <= distance_next;
        count_reg    <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        if (seen_re)
        begin
            seen_q_reg <= seen_mem[seen_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (hist_re)
        begin
            hist_q_reg <= hist_mem[hist_ra];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign distance  = distance_reg;
    assign count     = count_reg;

`ifndef NO_ASSERTIONS
    a_tail_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
        tail_seen |-> (state_reg == ST_WAVE))
        else $error("stack token left the chain outside an access");

    a_hit_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[STACK_DEPTH].hit |-> (tail_pos < DEPTH_CNT))
        else $error("hit position past the stack depth");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == ST_UPDATE || $past(state_reg) == ST_READOUT))
        else $error("result loaded outside the update or readout step");
`endif

endmodule

/* hdl/lrusd_cell.sv */
// One entry of the LRU stack: holds a key and its valid bit, swaps with the
// token from the cell above and hands the displaced key to the cell below.
// Depends on lrusd_pkg.

module lrusd_cell #(
    parameter int KEY_BITS = 16,
    parameter int POS_W    = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_BITS-1:0] probe,
    input  lrusd_pkg::tok_t     tok_in,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [POS_W-1:0]    pos_in,
    output lrusd_pkg::tok_t     tok_out,
    output logic [KEY_BITS-1:0] key_out,
    output logic [POS_W-1:0]    pos_out
);
    import lrusd_pkg::*;

    logic [KEY_BITS-1:0] ent_key_reg, ent_key_next;
    logic                ent_valid_reg, ent_valid_next;
    tok_t                tok_reg, tok_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                match;

    assign match = ent_valid_reg && (ent_key_reg == probe);

    always_comb
    begin
        ent_key_next   = ent_key_reg;
        ent_valid_next = ent_valid_reg;
        tok_next       = '0;
        key_next       = key_reg;
        pos_next       = pos_reg;
        if (tok_in.active)
        begin
            ent_key_next   = key_in;
            ent_valid_next = 1'b1;
            if (match)
            begin
                tok_next.done = 1'b1;
                tok_next.hit  = 1'b1;
                pos_next      = pos_in;
            end
            else if (!ent_valid_reg)
            begin
                tok_next.done = 1'b1;
                pos_next      = pos_in;
            end
            else
            begin
                // carry the displaced key one cell down
                tok_next.active = 1'b1;
                key_next        = ent_key_reg;
                pos_next        = pos_in + 1'b1;
            end
        end
        else if (tok_in.done)
        begin
            tok_next = tok_in;
            pos_next = pos_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            tok_reg       <= '0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            tok_reg       <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_key_reg <= ent_key_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;
    assign pos_out = pos_reg;

endmodule
